>>> sv/ctc_pkg.sv
`default_nettype none

package ctc_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [1:0] KIND_KEYWORD = 2'd0;
  localparam logic [1:0] KIND_NUMBER  = 2'd1;
  localparam logic [1:0] KIND_STRING  = 2'd2;

  localparam logic KW_ID      = 1'b0;
  localparam logic KW_CONNECT = 1'b1;

  localparam logic [7:0] ID_LEN      = 8'd2;
  localparam logic [7:0] CONNECT_LEN = 8'd7;
  localparam logic [7:0] HEX_MIN_LEN = 8'd3;
  localparam logic [7:0] HEX_MAX_LEN = 8'd6;
  localparam logic [7:0] SAT_MAX     = 8'd255;

  localparam int DATA_W = 40;
  localparam int USER_W = 3;

  typedef struct packed {
    logic        token_valid;
    logic [1:0]  token_index;
    logic [1:0]  token_kind;
    logic        keyword_code;
    logic [15:0] number_value;
    logic [7:0]  token_start;
    logic [7:0]  token_length;
    logic        message_end;
    logic [2:0]  token_count;
  } token_report_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic logic [7:0] id_char(input logic sel);
    return sel ? 8'h44 : 8'h49;
  endfunction

  function automatic logic [7:0] connect_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h43;
      3'd1:    ch = 8'h4F;
      3'd2:    ch = 8'h4E;
      3'd3:    ch = 8'h4E;
      3'd4:    ch = 8'h45;
      3'd5:    ch = 8'h43;
      3'd6:    ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic hex_digit_t hex_digit(input logic [7:0] ch);
    hex_digit_t d;
    d.ok    = 1'b0;
    d.value = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d.ok    = 1'b1;
      d.value = 4'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      d.ok    = 1'b1;
      d.value = 4'(ch - 8'h41 + 8'd10);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      d.ok    = 1'b1;
      d.value = 4'(ch - 8'h61 + 8'd10);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> sv/ctc_scan.sv
`default_nettype none

module ctc_scan #(
  parameter int TOKEN_LIMIT = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       char_in,
  output ctc_pkg::token_report_t res,
  output logic                  res_emit
);

  localparam int CNT_W = $clog2(TOKEN_LIMIT + 1);

  logic             in_token, in_token_next;
  logic [CNT_W-1:0] tokens_found, tokens_found_next;
  logic [7:0]       char_position, char_position_next;
  logic [7:0]       current_start, current_start_next;
  logic [7:0]       current_length, current_length_next;
  logic [1:0]       kw_match, kw_match_next;
  logic [15:0]      hex_acc, hex_acc_next;
  logic             hex_ok, hex_ok_next;
  logic             skip, skip_next;

  // feed values as seen by the next token character
  logic [7:0]          pos;
  logic [1:0]          kw_in;
  logic [15:0]         acc_in;
  logic                hv_in;
  logic [1:0]          kw_fed;
  logic [15:0]         acc_fed;
  logic                hv_fed;
  ctc_pkg::hex_digit_t dig;

  logic [7:0] cnt8;
  logic [7:0] cnt_inc8;
  logic [7:0] pos_sat;
  logic [1:0] kind;
  logic       code;
  logic [15:0] value;

  assign cnt8    = 8'(tokens_found);
  assign pos_sat = (char_position < ctc_pkg::SAT_MAX) ? char_position + 8'd1 : char_position;
  assign cnt_inc8 = cnt8 + 8'd1;

  always_comb begin
    pos    = in_token ? current_length : 8'd0;
    kw_in  = in_token ? kw_match : 2'b11;
    acc_in = in_token ? hex_acc : 16'd0;
    hv_in  = in_token ? hex_ok : 1'b1;
    dig    = ctc_pkg::hex_digit(char_in);

    kw_fed = kw_in;
    if (pos >= ctc_pkg::ID_LEN || char_in != ctc_pkg::id_char(pos[0])) begin
      kw_fed[0] = 1'b0;
    end
    if (pos >= ctc_pkg::CONNECT_LEN || char_in != ctc_pkg::connect_char(pos[2:0])) begin
      kw_fed[1] = 1'b0;
    end

    acc_fed = acc_in;
    hv_fed  = hv_in;
    if (pos == 8'd0) begin
      if (char_in != ctc_pkg::CH_ZERO) hv_fed = 1'b0;
    end else if (pos == 8'd1) begin
      if (char_in != ctc_pkg::CH_X) hv_fed = 1'b0;
    end else if (pos < ctc_pkg::HEX_MAX_LEN) begin
      if (dig.ok) begin
        acc_fed = {acc_in[11:0], dig.value};
      end else begin
        hv_fed = 1'b0;
      end
    end else begin
      hv_fed = 1'b0;
    end
  end

  // classification of the running token
  always_comb begin
    kind  = ctc_pkg::KIND_STRING;
    code  = ctc_pkg::KW_ID;
    value = 16'd0;
    if (kw_match[0] && current_length == ctc_pkg::ID_LEN) begin
      kind = ctc_pkg::KIND_KEYWORD;
      code = ctc_pkg::KW_ID;
    end else if (kw_match[1] && current_length == ctc_pkg::CONNECT_LEN) begin
      kind = ctc_pkg::KIND_KEYWORD;
      code = ctc_pkg::KW_CONNECT;
    end else if (hex_ok && current_length >= ctc_pkg::HEX_MIN_LEN &&
                 current_length <= ctc_pkg::HEX_MAX_LEN) begin
      kind  = ctc_pkg::KIND_NUMBER;
      value = hex_acc;
    end
  end

  always_comb begin
    in_token_next       = in_token;
    tokens_found_next   = tokens_found;
    char_position_next  = char_position;
    current_start_next  = current_start;
    current_length_next = current_length;
    kw_match_next       = kw_match;
    hex_acc_next        = hex_acc;
    hex_ok_next         = hex_ok;
    skip_next           = skip;

    res          = '0;
    res_emit     = 1'b0;
    res.token_count = (cnt8 > 8'd7) ? 3'd7 : cnt8[2:0];

    if (char_in == ctc_pkg::CH_NUL) begin
      res_emit        = 1'b1;
      res.message_end = 1'b1;
      if (in_token && !skip) begin
        res.token_valid  = 1'b1;
        res.token_index  = 2'(cnt8 - 8'd1);
        res.token_kind   = kind;
        res.keyword_code = code;
        res.number_value = value;
        res.token_start  = current_start;
        res.token_length = current_length;
      end
      in_token_next       = 1'b0;
      tokens_found_next   = '0;
      char_position_next  = 8'd0;
      current_start_next  = 8'd0;
      current_length_next = 8'd0;
      kw_match_next       = 2'b11;
      hex_acc_next        = 16'd0;
      hex_ok_next         = 1'b1;
      skip_next           = 1'b0;
    end else if (skip) begin
      char_position_next = pos_sat;
    end else if (char_in == ctc_pkg::CH_SPACE) begin
      if (in_token) begin
        res_emit         = 1'b1;
        res.token_valid  = 1'b1;
        res.token_index  = 2'(cnt8 - 8'd1);
        res.token_kind   = kind;
        res.keyword_code = code;
        res.number_value = value;
        res.token_start  = current_start;
        res.token_length = current_length;
        in_token_next    = 1'b0;
      end
      char_position_next = pos_sat;
    end else if (!in_token && cnt8 >= 8'(TOKEN_LIMIT)) begin
      skip_next          = 1'b1;
      char_position_next = pos_sat;
    end else begin
      if (!in_token) begin
        tokens_found_next  = CNT_W'(cnt_inc8);
        current_start_next = char_position;
      end
      in_token_next       = 1'b1;
      kw_match_next       = kw_fed;
      hex_acc_next        = acc_fed;
      hex_ok_next         = hv_fed;
      current_length_next = (pos < ctc_pkg::SAT_MAX) ? pos + 8'd1 : pos;
      char_position_next  = pos_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token       <= 1'b0;
      tokens_found   <= '0;
      char_position  <= 8'd0;
      current_start  <= 8'd0;
      current_length <= 8'd0;
      kw_match       <= 2'b11;
      hex_acc        <= 16'd0;
      hex_ok         <= 1'b1;
      skip           <= 1'b0;
    end else if (step) begin
      in_token       <= in_token_next;
      tokens_found   <= tokens_found_next;
      char_position  <= char_position_next;
      current_start  <= current_start_next;
      current_length <= current_length_next;
      kw_match       <= kw_match_next;
      hex_acc        <= hex_acc_next;
      hex_ok         <= hex_ok_next;
      skip           <= skip_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/command_token_classifier.sv
// command token classifier
// input: one message character per s_axis transfer; space (0x20) separates
// tokens and a zero byte ends the message
// output: one m_axis transfer per finished token, reporting its class
// (keyword ID/CONNECT, 0x-prefixed hex number of one to four digits, or
// string), its index, offset and length; the zero byte always gives one
// transfer with tlast high and the token count, then the scan starts over
// only the first TOKEN_LIMIT tokens of a message are reported, later
// characters up to the zero byte give no transfer
// a character is taken into the input register, scanned out of it once the
// output register is free, and its result is registered in the output register
// throughput: one character per cycle while no held result is stalled on
// m_axis, set by the single scan stage between the input register and the
// output register
// reset (rst, synchronous): both registers empty, scan state at start of
// message
// when the receiver stalls, the result holds on m_axis; s_axis_tready drops
// once the input register is full, so it takes at most one further character

`default_nettype none

module command_token_classifier #(
  parameter int TOKEN_LIMIT = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,    // char_in
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  // token_index[1:0], keyword_code[2], number_value[18:3], token_start[26:19],
  // token_length[34:27], token_count[37:35], zero fill[39:38]
  output logic [ctc_pkg::DATA_W-1:0] m_axis_tdata,
  // token_valid[0], token_kind[2:1]
  output logic [ctc_pkg::USER_W-1:0] m_axis_tuser,
  output logic            m_axis_tlast     // message_end
);

  // input register
  logic       in_full;
  logic [7:0] in_char;

  // scan stage
  logic                   out_free;
  logic                   step;
  ctc_pkg::token_report_t res;
  logic                   res_emit;

  // output register
  ctc_pkg::token_report_t out_res;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_full && out_free;
  assign s_axis_tready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
    end
  end

  ctc_scan #(
    .TOKEN_LIMIT(TOKEN_LIMIT)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .char_in  (in_char),
    .res      (res),
    .res_emit (res_emit)
  );

  // result register, loaded only when the character produced a result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= res_emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_emit) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {2'b00, out_res.token_count, out_res.token_length,
                         out_res.token_start, out_res.number_value,
                         out_res.keyword_code, out_res.token_index};
  assign m_axis_tuser = {out_res.token_kind, out_res.token_valid};
  assign m_axis_tlast = out_res.message_end;

endmodule

`default_nettype wire

>>> sv/ctc_checker.sv
`default_nettype none

module ctc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [ctc_pkg::DATA_W-1:0]  m_axis_tdata,
  input wire logic [ctc_pkg::USER_W-1:0]  m_axis_tuser,
  input wire logic                        m_axis_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a result without a token only comes from the end of a message
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("empty result without message end");

  // a result without a token carries zero token fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[34:0] == 35'd0 && m_axis_tuser[2:1] == 2'd0)
    else $error("empty result with token fields");

  // keyword code only on keywords, number value only on numbers
  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2:1] != ctc_pkg::KIND_KEYWORD |->
      !m_axis_tdata[2] &&
      (m_axis_tuser[2:1] == ctc_pkg::KIND_NUMBER || m_axis_tdata[18:3] == 16'd0))
    else $error("field set for the wrong kind");

  // a token never has kind code three
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3)
    else $error("invalid token kind");

endmodule

bind command_token_classifier ctc_checker u_ctc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top;

  localparam int TOKEN_LIMIT = 4;

  // scan state copy and queue of classifier results still to arrive
  class token_scoreboard;
    ctc_pkg::token_report_t expected_q[$];
    int          errors;
    string       id_word = "ID";
    string       connect_word = "CONNECT";
    bit          in_tok;
    int          found;
    logic [7:0]  pos;
    logic [7:0]  start;
    logic [7:0]  len;
    logic [1:0]  kw_live;
    logic [15:0] acc;
    bit          hex_live;
    bit          skip;

    function new();
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      in_tok   = 1'b0;
      found    = 0;
      pos      = 8'd0;
      start    = 8'd0;
      len      = 8'd0;
      kw_live  = 2'b11;
      acc      = 16'd0;
      hex_live = 1'b1;
      skip     = 1'b0;
    endfunction

    function void bump_pos();
      if (pos != ctc_pkg::SAT_MAX) pos++;
    endfunction

    function bit hex_of(logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= "0" && c <= "9") v = 4'(c - "0");
      else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
      else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
      else return 1'b0;
      return 1'b1;
    endfunction

    // classify the running token and close it
    function ctc_pkg::token_report_t finish_token();
      ctc_pkg::token_report_t r;
      r = '0;
      r.token_valid  = 1'b1;
      r.token_index  = 2'(found - 1);
      r.token_start  = start;
      r.token_length = len;
      if (kw_live[0] && len == ctc_pkg::ID_LEN) begin
        r.token_kind   = ctc_pkg::KIND_KEYWORD;
        r.keyword_code = ctc_pkg::KW_ID;
      end else if (kw_live[1] && len == ctc_pkg::CONNECT_LEN) begin
        r.token_kind   = ctc_pkg::KIND_KEYWORD;
        r.keyword_code = ctc_pkg::KW_CONNECT;
      end else if (hex_live && len >= ctc_pkg::HEX_MIN_LEN &&
                   len <= ctc_pkg::HEX_MAX_LEN) begin
        r.token_kind   = ctc_pkg::KIND_NUMBER;
        r.number_value = acc;
      end else begin
        r.token_kind = ctc_pkg::KIND_STRING;
      end
      in_tok = 1'b0;
      return r;
    endfunction

    function void feed(logic [7:0] c);
      logic [3:0] d;
      if (!(len < 2 && c == id_word[len])) kw_live[0] = 1'b0;
      if (!(len < 7 && c == connect_word[len])) kw_live[1] = 1'b0;
      if (len == 0) begin
        if (c != ctc_pkg::CH_ZERO) hex_live = 1'b0;
      end else if (len == 1) begin
        if (c != ctc_pkg::CH_X) hex_live = 1'b0;
      end else if (len < ctc_pkg::HEX_MAX_LEN) begin
        if (hex_of(c, d)) acc = {acc[11:0], d};
        else hex_live = 1'b0;
      end else begin
        hex_live = 1'b0;
      end
      if (len != ctc_pkg::SAT_MAX) len++;
    endfunction

    function void note_char(logic [7:0] c);
      ctc_pkg::token_report_t r;
      r = '0;
      if (c == ctc_pkg::CH_NUL) begin
        if (in_tok && !skip) r = finish_token();
        r.message_end = 1'b1;
        r.token_count = (found > 7) ? 3'd7 : 3'(found);
        expected_q.push_back(r);
        clear_scan();
        return;
      end
      if (skip) begin
        bump_pos();
        return;
      end
      if (c == ctc_pkg::CH_SPACE) begin
        if (in_tok) begin
          r = finish_token();
          r.token_count = (found > 7) ? 3'd7 : 3'(found);
          expected_q.push_back(r);
        end
        bump_pos();
        return;
      end
      if (!in_tok) begin
        if (found >= TOKEN_LIMIT) begin
          skip = 1'b1;
          bump_pos();
          return;
        end
        in_tok   = 1'b1;
        found++;
        start    = pos;
        len      = 8'd0;
        kw_live  = 2'b11;
        acc      = 16'd0;
        hex_live = 1'b1;
      end
      feed(c);
      bump_pos();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, int got, int exp);
      if (got != exp) report($sformatf("%s got %0d expected %0d", name, got, exp));
    endtask

    task check(ctc_pkg::token_report_t got);
      ctc_pkg::token_report_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", got));
        return;
      end
      exp = expected_q.pop_front();
      cmp("token_valid", got.token_valid, exp.token_valid);
      cmp("token_index", got.token_index, exp.token_index);
      cmp("token_kind", got.token_kind, exp.token_kind);
      cmp("keyword_code", got.keyword_code, exp.keyword_code);
      cmp("number_value", got.number_value, exp.number_value);
      cmp("token_start", got.token_start, exp.token_start);
      cmp("token_length", got.token_length, exp.token_length);
      cmp("message_end", got.message_end, exp.message_end);
      cmp("token_count", got.token_count, exp.token_count);
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata = 8'd0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [ctc_pkg::DATA_W-1:0]  m_axis_tdata;
  logic [ctc_pkg::USER_W-1:0]  m_axis_tuser;
  logic                        m_axis_tlast;

  token_scoreboard     sb;
  bit                  no_idle = 1'b0;
  int                  sent = 0;
  logic [7:0]          text_q[$];

  command_token_classifier #(
    .TOKEN_LIMIT(TOKEN_LIMIT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // one character per transfer, valid held high until accepted
  task send_char(logic [7:0] c);
    while (!no_idle && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_char(c);
    sent++;
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // sender idle until every expected result is back
  task drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function void push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function logic [7:0] any_char();
    logic [7:0] v;
    do v = 8'($urandom_range(1, 255)); while (v == ctc_pkg::CH_SPACE);
    return v;
  endfunction

  function logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(ctc_pkg::CH_ZERO + v);
    return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
  endfunction

  function logic [7:0] non_hex_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range("g", "z"));
      1:       return 8'($urandom_range("G", "Z"));
      2:       return 8'($urandom_range(8'h80, 8'hFF));
      default: return 8'($urandom_range("!", "/"));
    endcase
  endfunction

  function void push_spaces(int lo, int hi);
    repeat ($urandom_range(lo, hi)) text_q.push_back(ctc_pkg::CH_SPACE);
  endfunction

  function void add_token();
    string w;
    int    n;
    int    k;
    case ($urandom_range(0, 9))
      0: push_str("ID");
      1: push_str("CONNECT");
      2, 3: begin
        push_str("0x");
        repeat ($urandom_range(1, 4)) text_q.push_back(hex_char());
      end
      4: begin
        // too many digits
        push_str("0x");
        repeat ($urandom_range(5, 6)) text_q.push_back(hex_char());
      end
      5: begin
        // keyword near miss: short, extended or one letter changed
        w = $urandom_range(1) ? "CONNECT" : "ID";
        case ($urandom_range(0, 2))
          0: push_str(w.substr(0, $urandom_range(0, w.len() - 2)));
          1: begin
            push_str(w);
            text_q.push_back(any_char());
          end
          default: begin
            k = $urandom_range(0, w.len() - 1);
            w[k] = w[k] | 8'h20;
            push_str(w);
          end
        endcase
      end
      6: begin
        // hex prefix with a non-hex digit somewhere
        push_str("0x");
        n = $urandom_range(1, 4);
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) text_q.push_back(i == k ? non_hex_char() : hex_char());
      end
      7: repeat ($urandom_range(1, 8)) text_q.push_back(any_char());
      8: case ($urandom_range(0, 3))
        0: push_str("0");
        1: push_str("0x");
        2: push_str("x");
        default: text_q.push_back(any_char());
      endcase
      default: begin
        push_str("0X");
        repeat ($urandom_range(1, 4)) text_q.push_back(hex_char());
      end
    endcase
  endfunction

  function void build_message();
    int ntok;
    text_q.delete();
    if ($urandom_range(3) == 0) push_spaces(1, 2);
    ntok = $urandom_range(0, 6);
    for (int i = 0; i < ntok; i++) begin
      add_token();
      if (i < ntok - 1) push_spaces(1, 3);
    end
    if ($urandom_range(3) == 0) push_spaces(1, 2);
    text_q.push_back(ctc_pkg::CH_NUL);
  endfunction

  function void build_noise();
    text_q.delete();
    repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
    text_q.push_back(ctc_pkg::CH_NUL);
  endfunction

  // one token of 250 to 300 characters, then tokens that start past offset 250
  function void build_long();
    text_q.delete();
    repeat ($urandom_range(250, 300)) text_q.push_back(any_char());
    push_str(" ID 0xAB");
    text_q.push_back(ctc_pkg::CH_NUL);
  endfunction

  task send_queue();
    foreach (text_q[i]) send_char(text_q[i]);
  endtask

  initial begin
    ctc_pkg::token_report_t got;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got              = '0;
        got.token_valid  = m_axis_tuser[0];
        got.token_kind   = m_axis_tuser[2:1];
        got.token_index  = m_axis_tdata[1:0];
        got.keyword_code = m_axis_tdata[2];
        got.number_value = m_axis_tdata[18:3];
        got.token_start  = m_axis_tdata[26:19];
        got.token_length = m_axis_tdata[34:27];
        got.token_count  = m_axis_tdata[37:35];
        got.message_end  = m_axis_tlast;
        sb.check(got);
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 34);
    end
  end

  initial begin
    int msg_no;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: keyword and number ended by the zero byte, empty message,
    // non-hex digit, high-bit byte and tokens past the limit
    send_text("ID 0xF1");
    send_char(ctc_pkg::CH_NUL);
    send_char(ctc_pkg::CH_NUL);
    send_text("CONNECT 0xG a b ");
    send_char(8'hFF);
    send_char(ctc_pkg::CH_NUL);

    // sender holds off until everything is back
    drain();

    msg_no = 0;
    while (sent < 1050) begin
      no_idle = (sent >= 400 && sent < 600);
      if (msg_no == 10 || msg_no == 120) build_long();
      else if ($urandom_range(99) < 88) build_message();
      else build_noise();
      send_queue();
      if (msg_no == 40) drain();
      msg_no++;
    end
    no_idle = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
